### sv/lcdt_pkg.sv
// Package for the wrapping character terminal.
// Holds the shared constants, the queued job type and the command codes.
// Depends on nothing; all other files import it.
package lcdt_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] CMD_ROW0     = 8'h80;
    localparam logic [7:0] CMD_ROW1     = 8'hC0;

    // One classified character as handed from the front to the back.
    typedef struct packed {
        logic       blank;   // pause, blank both rows, home the cursor
        logic       newrow;  // move to the start of row 1
        logic       data;    // write the character itself
        logic [7:0] ch;
    } job_t;

endpackage

### sv/lcdt_front.sv
// Front part of the terminal: accepts characters and classifies them.
// Keeps the cursor row and column. Depends on lcdt_pkg.
module lcdt_front #(
    parameter int COLUMNS = lcdt_pkg::COLUMNS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_code,
    input  logic          q_full,
    output logic          q_push,
    output lcdt_pkg::job_t q_job
);
    import lcdt_pkg::*;

    localparam int CW = $clog2(COLUMNS + 1);

    logic          row_reg;
    logic          row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          is_nl;
    logic          col_full;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign is_nl    = (char_code == NEWLINE_CODE);
    assign col_full = (col_reg >= CW'(COLUMNS));

    always_comb
    begin
        q_job.blank  = 1'b0;
        q_job.newrow = 1'b0;
        q_job.data   = !is_nl;
        q_job.ch     = char_code;
        row_next     = row_reg;
        col_next     = col_reg;
        if (is_nl)
        begin
            q_job.blank  = row_reg;
            q_job.newrow = !row_reg;
            row_next     = !row_reg;
            col_next     = '0;
        end
        else if (col_full)
        begin
            q_job.blank  = row_reg;
            q_job.newrow = !row_reg;
            row_next     = !row_reg;
            col_next     = CW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 1'b0;
            col_reg <= '0;
        end
        else if (q_push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

### sv/lcdt_queue.sv
// Short job queue between the front and the back of the terminal.
// Flop-based FIFO of QUEUE_DEPTH entries (a power of two). Depends on lcdt_pkg.
module lcdt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcdt_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output lcdt_pkg::job_t head_job
);
    import lcdt_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

### sv/lcdt_back.sv
// Back part of the terminal: turns one queued job into controller bus items.
// Sequencer with a space counter and an output register. Depends on lcdt_pkg.
module lcdt_back #(
    parameter int COLUMNS = lcdt_pkg::COLUMNS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  lcdt_pkg::job_t q_job,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           is_data,
    output logic [7:0]     bus_byte,
    output logic           pause_before,
    output logic           last
);
    import lcdt_pkg::*;

    localparam int SW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOME0,
        S_SP0,
        S_ROW1,
        S_SP1,
        S_HOME,
        S_NEWROW,
        S_DATA
    } state_t;

    state_t        state_reg;
    job_t          job_reg;
    logic [SW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic          is_data_reg;
    logic [7:0]    bus_byte_reg;
    logic          pause_reg;
    logic          last_reg;
    logic          out_free;
    logic          cnt_end;
    logic          emit;

    assign out_free     = !out_valid_reg || !out_stall;
    assign cnt_end      = (cnt_reg == SW'(COLUMNS - 1));
    // Every state except idle loads one transaction whenever the register is free.
    assign emit         = (state_reg != S_IDLE) && out_free;
    assign q_pop        = (state_reg == S_IDLE) && q_not_empty;
    assign out_valid    = out_valid_reg;
    assign is_data      = is_data_reg;
    assign bus_byte     = bus_byte_reg;
    assign pause_before = pause_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            is_data_reg   <= 1'b0;
            bus_byte_reg  <= '0;
            pause_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        job_reg <= q_job;
                        cnt_reg <= '0;
                        if (q_job.blank)
                        begin
                            state_reg <= S_HOME0;
                        end
                        else if (q_job.newrow)
                        begin
                            state_reg <= S_NEWROW;
                        end
                        else
                        begin
                            state_reg <= S_DATA;
                        end
                    end
                end
                S_HOME0:
                begin
                    if (out_free)
                    begin
                        is_data_reg   <= 1'b0;
                        bus_byte_reg  <= CMD_ROW0;
                        pause_reg     <= 1'b1;
                        last_reg      <= 1'b0;
                        state_reg     <= S_SP0;
                    end
                end
                S_SP0, S_SP1:
                begin
                    if (out_free)
                    begin
                        is_data_reg   <= 1'b1;
                        bus_byte_reg  <= SPACE_CODE;
                        pause_reg     <= 1'b0;
                        last_reg      <= 1'b0;
                        cnt_reg       <= cnt_end ? '0 : cnt_reg + SW'(1);
                        if (cnt_end)
                        begin
                            state_reg <= (state_reg == S_SP0) ? S_ROW1 : S_HOME;
                        end
                    end
                end
                S_ROW1:
                begin
                    if (out_free)
                    begin
                        is_data_reg   <= 1'b0;
                        bus_byte_reg  <= CMD_ROW1;
                        pause_reg     <= 1'b0;
                        last_reg      <= 1'b0;
                        state_reg     <= S_SP1;
                    end
                end
                S_HOME, S_NEWROW:
                begin
                    if (out_free)
                    begin
                        is_data_reg   <= 1'b0;
                        bus_byte_reg  <= (state_reg == S_HOME) ? CMD_ROW0 : CMD_ROW1;
                        pause_reg     <= 1'b0;
                        last_reg      <= !job_reg.data;
                        state_reg     <= job_reg.data ? S_DATA : S_IDLE;
                    end
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        is_data_reg   <= 1'b1;
                        bus_byte_reg  <= job_reg.ch;
                        pause_reg     <= 1'b0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/char_lcd_wrapping_terminal.sv
// Top level of the wrapping two-row character terminal.
// Instantiates lcdt_front, lcdt_queue and lcdt_back; depends on lcdt_pkg.
//
// Usage: characters arrive on the input channel (in_valid, in_stall,
// char_code). Each accepted transaction is classified against the cursor
// and produces a run of controller bus transactions on the output channel
// (out_valid, out_stall, is_data, bus_byte, pause_before, last). The final
// transaction of each run carries last = 1.
// A printable character yields one data byte. A newline or a wrap on row 0
// yields the row 1 address command. A newline or a wrap on row 1 yields the
// blank-and-home run of 2*COLUMNS+3 transactions, the first one flagged with
// pause_before. On a wrap on either row, the character itself follows.
// The accepted character is written to the job queue, the back sequencer
// pops it while idle, and the state it enters loads the first transaction
// into the output register. The back sequencer emits one transaction per
// cycle while the receiver does not stall, and passes through idle to fetch
// the next job after each run. That sequencer sets the rate.
// A two-entry job queue decouples the sides, so characters are still taken
// while a run is draining; in_stall rises only when the queue is full.
// When the receiver stalls, the held transaction stays unchanged and the
// sequencer waits. Reset empties the queue, drops out_valid and puts the
// cursor at row 0, column 0.
module char_lcd_wrapping_terminal #(
    parameter int COLUMNS = lcdt_pkg::COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       pause_before,
    output logic       last
);
    import lcdt_pkg::*;

    // Handshake between the front, the queue and the back.
    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;

    // The front updates the cursor when it pushes, so the cursor always
    // reflects every character taken so far, regardless of the back.
    lcdt_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .q_full    (q_full),
        .q_push    (push),
        .q_job     (push_job)
    );

    lcdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // The back holds one transaction in its output register and, within a run,
    // refills it in the same cycle that the receiver takes it.
    lcdt_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_job        (head_job),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_data      (is_data),
        .bus_byte     (bus_byte),
        .pause_before (pause_before),
        .last         (last)
    );

endmodule

### sv/lcdt_checker.sv
// Port-level checker for the wrapping character terminal, bound to the top.
// Depends on lcdt_pkg for the command and space codes.
module lcdt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_data,
    input logic [7:0] bus_byte,
    input logic       pause_before,
    input logic       last
);
    import lcdt_pkg::*;

    // A stalled transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_byte) && $stable(is_data)
            && $stable(last) && $stable(pause_before))
    else $error("output transaction changed while stalled");

    // The pause only ever precedes the home command that opens a blank run.
    a_pause_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pause_before |-> !is_data && !last && bus_byte == CMD_ROW0)
    else $error("pause flag on an item other than the blank-run home command");

    // Once the opening command is taken, the first space follows at once.
    a_pause_then_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pause_before && !out_stall |=> out_valid && is_data
            && bus_byte == SPACE_CODE && !last)
    else $error("blank run did not continue with a space");

    // A run that ends on a command ends on one of the two row addresses.
    a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !is_data |-> bus_byte == CMD_ROW0 || bus_byte == CMD_ROW1)
    else $error("run ended on an unexpected command");

endmodule

bind char_lcd_wrapping_terminal lcdt_checker u_lcdt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_data      (is_data),
    .bus_byte     (bus_byte),
    .pause_before (pause_before),
    .last         (last)
);
